// File: src/tcbf_pkg.sv
// Shared types, codes and lookup tables for the cassette block framer.
`default_nettype none
package tcbf_pkg;

  localparam int PAYLOAD_MAX_DEF = 254;
  localparam int SYNC_COUNT_DEF  = 16;
  localparam int FQ_DEPTH        = 2;
  localparam int OQ_DEPTH        = 4;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_FINISH = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_RETRY     = 2'd1;
  localparam logic [1:0] ST_NO_OUTPUT = 2'd2;
  localparam logic [1:0] ST_FINISHED  = 2'd3;

  localparam logic [7:0] BYTE_ESC  = 8'h16;
  localparam logic [7:0] BYTE_LF   = 8'h0a;
  localparam logic [7:0] BYTE_CR   = 8'h0d;
  localparam logic [7:0] SYNC_BYTE = 8'h01;
  localparam logic [7:0] MARK_1    = 8'h3c;
  localparam logic [7:0] MARK_2    = 8'h5a;
  localparam logic [7:0] TYPE_DATA = 8'h01;
  localparam logic [7:0] TYPE_END  = 8'hff;
  localparam logic [7:0] END_LEN   = 8'h02;
  localparam logic [7:0] END_CHK   = 8'h00;

  localparam int ACCENT_N = 13;
  localparam logic [7:0] ACCENT_CODE [ACCENT_N] = '{
    8'he0, 8'he2, 8'he7, 8'he8, 8'he9, 8'hea, 8'heb, 8'hee, 8'hef, 8'hf4, 8'hf6, 8'hf9, 8'hfc
  };
  localparam logic [7:0] ACCENT_FIRST [ACCENT_N] = '{
    8'h41, 8'h43, 8'h4b, 8'h41, 8'h42, 8'h43, 8'h48, 8'h43, 8'h48, 8'h43, 8'h48, 8'h41, 8'h48
  };
  localparam logic [7:0] ACCENT_SECOND [ACCENT_N] = '{
    8'h61, 8'h61, 8'h63, 8'h65, 8'h65, 8'h65, 8'h65, 8'h69, 8'h69, 8'h6f, 8'h6f, 8'h75, 8'h75
  };

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] text_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] out_byte;
    logic       block_end;
    logic       stream_end;
  } out_item_t;

  typedef enum logic [2:0] {
    K_APPEND1 = 3'd0,
    K_APPEND3 = 3'd1,
    K_FINISH  = 3'd2,
    K_READ    = 3'd3,
    K_NOP     = 3'd4
  } kind_t;

  // classified item handed from front to back
  typedef struct packed {
    kind_t      kind;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } cls_item_t;

  typedef struct packed {
    logic full;
    logic afull;
  } oq_status_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] first;
    logic [7:0] second;
  } accent_t;

  function automatic accent_t accent_lookup(input logic [7:0] b);
    accent_t r;
    r = '0;
    for (int i = 0; i < ACCENT_N; i++) begin
      if (ACCENT_CODE[i] == b) begin
        r.hit    = 1'b1;
        r.first  = ACCENT_FIRST[i];
        r.second = ACCENT_SECOND[i];
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: src/text_to_cassette_block_framer.sv
// Text to cassette block framer: top level.
// Usage:
//   Input queue: drive in_item and raise in_push; the item is taken at a clock
//   edge where in_full is low. Operations are append a text byte, finish the
//   stream, and read the next framed byte. Every item yields exactly one result.
//   Output queue: while out_empty is low, out_item holds the oldest result;
//   raise out_pop to take it.
// Path: an item passes the input queue, the result register and the output queue.
// Throughput: one item per cycle while the output queue has room, except an
//   accented append: the back end holds for three store writes, one per cycle.
// The payload store is one RAM with a single write and a single read port;
//   a data byte is read in the cycle before its result is formed.
// Reset: clears the queues, counters and framing state; the payload store is
//   not cleared since only written entries are ever read back.
// Stall: when out_pop stays low the 4-entry output queue fills, then the back
//   end stops, the 2-entry input queue fills and in_full rises. No item is lost.
`default_nettype none
module text_to_cassette_block_framer #(
  parameter int PAYLOAD_MAX = tcbf_pkg::PAYLOAD_MAX_DEF,
  parameter int SYNC_COUNT  = tcbf_pkg::SYNC_COUNT_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_push,
  input  wire tcbf_pkg::in_item_t  in_item,
  output logic                     in_full,
  input  wire logic                out_pop,
  output tcbf_pkg::out_item_t      out_item,
  output logic                     out_empty
);

  import tcbf_pkg::*;

  cls_item_t  q_item;
  logic       q_empty;
  logic       q_pop;
  oq_status_t oq_status;
  logic       res_valid;
  out_item_t  res_item;

  tcbf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_item (in_item),
    .in_full (in_full),
    .q_pop   (q_pop),
    .q_item  (q_item),
    .q_empty (q_empty)
  );

  tcbf_back #(
    .PAYLOAD_MAX(PAYLOAD_MAX),
    .SYNC_COUNT (SYNC_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_item    (q_item),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .oq_status (oq_status),
    .res_valid (res_valid),
    .res_item  (res_item)
  );

  tcbf_fifo #(
    .WIDTH($bits(out_item_t)),
    .DEPTH(OQ_DEPTH)
  ) u_oq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_valid),
    .wr_data (res_item),
    .full    (oq_status.full),
    .afull   (oq_status.afull),
    .rd_en   (out_pop),
    .rd_data (out_item),
    .empty   (out_empty)
  );

endmodule
`default_nettype wire

// File: src/tcbf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tcbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

// File: src/tcbf_fifo.sv
// Small register-based FIFO with full and almost-full flags.
`default_nettype none
module tcbf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  output logic                  afull,
  input  wire logic             rd_en,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] CNT_AF   = CNT_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_rd;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == CNT_FULL);
  assign afull   = (cnt_r >= CNT_AF);
  assign rd_data = mem_r[rd_ptr_r];
  assign do_rd   = rd_en && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (wr_en && !do_rd) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (!wr_en && do_rd) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

// File: src/tcbf_front.sv
// Front end: accepts items, decodes the operation, expands text bytes, queues them.
`default_nettype none
module tcbf_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_push,
  input  wire tcbf_pkg::in_item_t  in_item,
  output logic                     in_full,
  input  wire logic                q_pop,
  output tcbf_pkg::cls_item_t      q_item,
  output logic                     q_empty
);

  import tcbf_pkg::*;

  cls_item_t cls;
  accent_t   acc;
  logic      wr_en;

  assign acc   = accent_lookup(in_item.text_byte);
  assign wr_en = in_push && !in_full;

  always_comb begin
    cls = '0;
    unique case (in_item.operation)
      OP_APPEND: begin
        if (acc.hit) begin
          cls.kind = K_APPEND3;
          cls.b0   = BYTE_ESC;
          cls.b1   = acc.first;
          cls.b2   = acc.second;
        end else begin
          cls.kind = K_APPEND1;
          cls.b0   = (in_item.text_byte == BYTE_LF) ? BYTE_CR : in_item.text_byte;
        end
      end
      OP_FINISH: cls.kind = K_FINISH;
      OP_READ:   cls.kind = K_READ;
      default:   cls.kind = K_NOP;
    endcase
  end

  tcbf_fifo #(
    .WIDTH($bits(cls_item_t)),
    .DEPTH(FQ_DEPTH)
  ) u_fq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_data (cls),
    .full    (in_full),
    .afull   (),
    .rd_en   (q_pop),
    .rd_data (q_item),
    .empty   (q_empty)
  );

endmodule
`default_nettype wire

// File: src/tcbf_back.sv
// Back end: payload buffer, block framing sequencer and result stage.
`default_nettype none
module tcbf_back #(
  parameter int PAYLOAD_MAX = tcbf_pkg::PAYLOAD_MAX_DEF,
  parameter int SYNC_COUNT  = tcbf_pkg::SYNC_COUNT_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire tcbf_pkg::cls_item_t   q_item,
  input  wire logic                  q_empty,
  output logic                       q_pop,
  input  wire tcbf_pkg::oq_status_t  oq_status,
  output logic                       res_valid,
  output tcbf_pkg::out_item_t        res_item
);

  import tcbf_pkg::*;

  localparam int DEPTH  = PAYLOAD_MAX + 2;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int FILL_W = $clog2(PAYLOAD_MAX + 3);
  localparam int SPOS_W = $clog2(SYNC_COUNT + 5);
  localparam int POS_W  = (FILL_W > SPOS_W) ? FILL_W : SPOS_W;

  localparam logic [FILL_W-1:0] FILL_LIMIT = FILL_W'(PAYLOAD_MAX);
  localparam logic [POS_W-1:0]  P_MARK1    = POS_W'(SYNC_COUNT);
  localparam logic [POS_W-1:0]  P_MARK2    = POS_W'(SYNC_COUNT + 1);
  localparam logic [POS_W-1:0]  P_TYPE     = POS_W'(SYNC_COUNT + 2);
  localparam logic [POS_W-1:0]  P_LEN      = POS_W'(SYNC_COUNT + 3);
  localparam logic [POS_W-1:0]  P_LAST     = POS_W'(SYNC_COUNT + 4);

  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_HEAD  = 5'b00010,
    PH_DATA  = 5'b00100,
    PH_CHECK = 5'b01000,
    PH_END   = 5'b10000
  } phase_t;

  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [7:0]        sum_r, sum_nxt;
  phase_t            phase_r, phase_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              ready_r, ready_nxt;
  logic              finish_r, finish_nxt;
  logic              done_r, done_nxt;
  logic [1:0]        step_r, step_nxt;

  logic              s2_valid_r;
  out_item_t         s2_item_r;
  logic              s2_sel_ram_r;

  logic              go;
  logic              room;
  logic              st1_valid;
  out_item_t         st1_item;
  logic              st1_sel_ram;
  phase_t            eff_ph;
  logic [POS_W-1:0]  eff_p;
  logic [POS_W-1:0]  p_inc;
  logic              ram_we;
  logic [7:0]        ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_q;

  // a result may only start if the output queue can still absorb it
  assign room = !oq_status.full && !(oq_status.afull && s2_valid_r);
  assign go   = !q_empty && ((step_r != 2'd0) || room);

  always_comb begin
    fill_nxt    = fill_r;
    sum_nxt     = sum_r;
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    ready_nxt   = ready_r;
    finish_nxt  = finish_r;
    done_nxt    = done_r;
    step_nxt    = step_r;
    q_pop       = 1'b0;
    st1_valid   = 1'b0;
    st1_item    = '0;
    st1_sel_ram = 1'b0;
    ram_we      = 1'b0;
    ram_wdata   = q_item.b0;
    ram_raddr   = '0;
    eff_ph      = phase_r;
    eff_p       = pos_r;
    p_inc       = pos_r + POS_W'(1);

    if (go) begin
      unique case (q_item.kind)
        K_APPEND1, K_APPEND3: begin
          if (step_r == 2'd0) begin
            st1_valid = 1'b1;
            if (finish_r) begin
              st1_item.status = ST_FINISHED;
              q_pop = 1'b1;
            end else if (ready_r) begin
              st1_item.status = ST_RETRY;
              q_pop = 1'b1;
            end else if (fill_r >= FILL_LIMIT) begin
              st1_item.status = ST_RETRY;
              ready_nxt = 1'b1;
              q_pop = 1'b1;
            end else begin
              ram_we = 1'b1;
              if (q_item.kind == K_APPEND3) begin
                step_nxt = 2'd1;
              end else begin
                q_pop = 1'b1;
              end
            end
          end else begin
            // second and third byte of an accent expansion
            ram_we    = 1'b1;
            ram_wdata = (step_r == 2'd1) ? q_item.b1 : q_item.b2;
            if (step_r == 2'd2) begin
              step_nxt = 2'd0;
              q_pop    = 1'b1;
            end else begin
              step_nxt = 2'd2;
            end
          end
          if (ram_we) begin
            fill_nxt = fill_r + FILL_W'(1);
            sum_nxt  = sum_r + ram_wdata;
          end
        end
        K_FINISH: begin
          st1_valid = 1'b1;
          q_pop     = 1'b1;
          if (finish_r) begin
            st1_item.status = ST_FINISHED;
          end else begin
            finish_nxt = 1'b1;
            ready_nxt  = 1'b1;
          end
        end
        K_READ: begin
          st1_valid = 1'b1;
          q_pop     = 1'b1;
          if (done_r) begin
            st1_item.status = ST_FINISHED;
          end else if (phase_r == PH_IDLE && !ready_r) begin
            st1_item.status = ST_NO_OUTPUT;
          end else begin
            if (phase_r == PH_IDLE) begin
              eff_ph = PH_HEAD;
              eff_p  = '0;
            end
            p_inc = eff_p + POS_W'(1);
            unique case (eff_ph)
              PH_HEAD: begin
                if (eff_p < P_MARK1)       st1_item.out_byte = SYNC_BYTE;
                else if (eff_p == P_MARK1) st1_item.out_byte = MARK_1;
                else if (eff_p == P_MARK2) st1_item.out_byte = MARK_2;
                else if (eff_p == P_TYPE)  st1_item.out_byte = TYPE_DATA;
                else                       st1_item.out_byte = 8'(fill_r) + 8'd2;
                if (eff_p >= P_LEN) begin
                  phase_nxt = (fill_r == '0) ? PH_CHECK : PH_DATA;
                  pos_nxt   = '0;
                end else begin
                  phase_nxt = PH_HEAD;
                  pos_nxt   = p_inc;
                end
              end
              PH_DATA: begin
                ram_raddr   = eff_p[ADDR_W-1:0];
                st1_sel_ram = 1'b1;
                if (p_inc >= POS_W'(fill_r)) begin
                  phase_nxt = PH_CHECK;
                  pos_nxt   = '0;
                end else begin
                  pos_nxt = p_inc;
                end
              end
              PH_CHECK: begin
                st1_item.out_byte  = 8'd0 - sum_r;
                st1_item.block_end = 1'b1;
                fill_nxt = '0;
                sum_nxt  = '0;
                pos_nxt  = '0;
                if (finish_r) begin
                  phase_nxt = PH_END;
                end else begin
                  phase_nxt = PH_IDLE;
                  ready_nxt = 1'b0;
                end
              end
              PH_END: begin
                if (eff_p < P_MARK1)       st1_item.out_byte = SYNC_BYTE;
                else if (eff_p == P_MARK1) st1_item.out_byte = MARK_1;
                else if (eff_p == P_MARK2) st1_item.out_byte = MARK_2;
                else if (eff_p == P_TYPE)  st1_item.out_byte = TYPE_END;
                else if (eff_p == P_LEN)   st1_item.out_byte = END_LEN;
                else                       st1_item.out_byte = END_CHK;
                if (eff_p >= P_LAST) begin
                  st1_item.block_end  = 1'b1;
                  st1_item.stream_end = 1'b1;
                  done_nxt  = 1'b1;
                  ready_nxt = 1'b0;
                  phase_nxt = PH_IDLE;
                  pos_nxt   = '0;
                end else begin
                  pos_nxt = p_inc;
                end
              end
              default: ;
            endcase
          end
        end
        default: begin
          st1_valid = 1'b1;
          q_pop     = 1'b1;
        end
      endcase
    end
  end

  tcbf_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_r[ADDR_W-1:0]),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= '0;
      sum_r      <= '0;
      phase_r    <= PH_IDLE;
      pos_r      <= '0;
      ready_r    <= 1'b0;
      finish_r   <= 1'b0;
      done_r     <= 1'b0;
      step_r     <= 2'd0;
      s2_valid_r <= 1'b0;
    end else begin
      fill_r     <= fill_nxt;
      sum_r      <= sum_nxt;
      phase_r    <= phase_nxt;
      pos_r      <= pos_nxt;
      ready_r    <= ready_nxt;
      finish_r   <= finish_nxt;
      done_r     <= done_nxt;
      step_r     <= step_nxt;
      s2_valid_r <= st1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_item_r    <= st1_item;
    s2_sel_ram_r <= st1_sel_ram;
  end

  // payload bytes arrive from the store in the cycle after the address
  always_comb begin
    res_item = s2_item_r;
    if (s2_sel_ram_r) begin
      res_item.out_byte = ram_q;
    end
  end

  assign res_valid = s2_valid_r;

endmodule
`default_nettype wire
